// ----- sv/clbf_pkg.sv -----
// ----------------------------------------------------------------------------
// clbf_pkg
// Shared types and constants of the cache line Bloom filter: request and
// result structs, register indexes, action codes and controller states.
// ----------------------------------------------------------------------------
package clbf_pkg;

    // field and register widths
    localparam int HASH_W    = 32;
    localparam int WORD_W    = 64;
    localparam int CFG_W     = 24;
    localparam int REG_IDX_W = 2;
    localparam int LINE_SEL_W = 8;
    localparam int PROBE_W   = 8;
    localparam int COUNT_W   = 24;

    // probe step is the hash rotated right by STEP_ROT
    localparam int STEP_ROT  = 17;

    // serial remainder: two hash bits per cycle
    localparam int DIV_STEPS  = 16;
    localparam int WRAP_STEPS = 4;
    localparam int STEP_CNT_W = 4;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_LINE_COUNT  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_PROBE_COUNT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_KEY_LIMIT   = 2'd2;

    // action codes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;

    typedef struct packed {
        logic              action;
        logic [HASH_W-1:0] key_hash;
    } req_t;

    typedef struct packed {
        logic may_match;
        logic is_full;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_WRAP,
        ST_SETUP,
        ST_READ,
        ST_TEST,
        ST_DONE
    } state_t;

    // rotate right by the probe step amount
    function automatic logic [HASH_W-1:0] probe_step(input logic [HASH_W-1:0] h);
        return (h >> STEP_ROT) | (h << (HASH_W - STEP_ROT));
    endfunction

endpackage

// ----- sv/cache_line_bloom_filter_top.sv -----
// ----------------------------------------------------------------------------
// cache_line_bloom_filter_top
// Blocked Bloom filter over 32-bit key hashes: insert or query one hash per
// request, bits held in a synchronous word memory with one write and one read port.
// ----------------------------------------------------------------------------
// usage
//   request: drive req and raise start; it is taken on a clock edge where
//   busy is low. one result per request appears on rsp with done high for
//   exactly one cycle; the receiver cannot stall, so it must take it then.
//   configuration: cfg_write with cfg_index/cfg_data, only while busy is low
//   and no result is pending.
// timing
//   the hash is reduced modulo the line count by a serial remainder lane at
//   two bits per cycle, followed by a wrap pass when MAX_LINES is below 256
//   (line index wrap). the hash and the probe step are reduced modulo the
//   line bit count by reciprocal multiply during that remainder pass. each
//   probe then reads its word (registered read), then tests the bit or
//   writes it back.
//   a new request is taken only after the result of the last one; a query
//   stops at a clear bit; with line count zero it skips the pass and probes.
// reset
//   after reset the block clears the bit store one word per cycle, all
//   MAX_LINES * ceil(LINE_BYTES/8) words (2048 by default), with busy high.
//   configuration writes are taken during that pass.
// ----------------------------------------------------------------------------
module cache_line_bloom_filter_top #(
    parameter int LINE_BYTES = 64,
    parameter int MAX_LINES  = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  clbf_pkg::req_t                 req,
    output logic                           busy,
    output logic                           done,
    output clbf_pkg::rsp_t                 rsp,
    input  logic                           cfg_write,
    input  logic [clbf_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [clbf_pkg::CFG_W-1:0]     cfg_data
);
    import clbf_pkg::*;

    localparam int LINE_BITS   = LINE_BYTES * 8;
    localparam int PW          = $clog2(LINE_BITS);
    localparam int WPL         = (LINE_BYTES + 7) / 8;
    localparam int STORE_WORDS = MAX_LINES * WPL;
    localparam int AW          = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam int LW          = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam bit WRAP_NEEDED = (MAX_LINES < (1 << LINE_SEL_W));
    localparam longint WRAP_ADJ = (64'd1 << HASH_W) % LINE_BITS;
    localparam logic signed [PW+1:0] LINE_BITS_S = (PW+2)'(LINE_BITS);
    localparam logic signed [PW+1:0] WRAP_ADJ_S  = (PW+2)'(WRAP_ADJ);

    // modulo line bits: low three bits kept, bits above them reduced modulo LINE_BYTES
    localparam int HX  = HASH_W - 3;
    localparam int LBW = PW - 3;
    localparam int RSH = HX + LBW;
    localparam int MW  = HX + 2;
    localparam longint RECIP = ((64'd1 << RSH) + LINE_BYTES - 1) / LINE_BYTES;
    localparam logic [MW-1:0] RECIP_V = MW'(RECIP);

    state_t state_reg;
    state_t state_next;

    // configuration and counters
    logic [LINE_SEL_W-1:0] line_count_reg;
    logic [PROBE_W-1:0]    probe_count_reg;
    logic [COUNT_W-1:0]    key_limit_reg;
    logic [COUNT_W-1:0]    keys_reg;
    logic [STEP_CNT_W-1:0] cnt_reg;
    logic [PROBE_W-1:0]    pcnt_reg;
    logic [AW-1:0]         clr_addr_reg;

    // item payload
    logic [HASH_W-1:0] h_reg;
    logic [HASH_W-1:0] step_reg;
    logic              act_reg;
    logic              match_reg;
    logic [PW-1:0]     pos_reg;
    logic [AW-1:0]     addr_reg;

    // control
    logic accept;
    logic div_en;
    logic wrap_en;
    logic ram_re;
    logic ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;

    // datapath
    logic [HASH_W-1:0]     h_sh;
    logic [LINE_SEL_W-1:0] line_rem;
    logic [LW-1:0]         line_idx;
    logic [AW-1:0]         addr_w;
    logic [WORD_W-1:0]     bit_mask;
    logic                  bit_set;
    logic [HASH_W-1:0]     h_sum;
    logic                  h_carry;
    logic signed [PW+1:0]  pos_t;
    logic [PW-1:0]         pos_next;

    // line bit reduction of hash and step
    logic [HASH_W-1:0]  red_src;
    logic [HX-1:0]      red_x;
    logic [HX+MW-1:0]   red_prod_reg;
    logic [HX-1:0]      red_qd_reg;
    logic [LBW-1:0]     red_rem;
    logic [PW-1:0]      red_mod;
    logic [PW-1:0]      pos_base_reg;
    logic [PW-1:0]      step_rem_reg;

    assign accept = start && (state_reg == ST_IDLE);

    // hash bits fed msb first, two per cycle
    assign h_sh = h_reg << {cnt_reg, 1'b0};

    // line = hash mod line count
    clbf_rem_lane #(.W(LINE_SEL_W)) u_line_lane (
        .clk     (clk),
        .clr     (accept),
        .en      (div_en),
        .din     (h_sh[HASH_W-1 -: 2]),
        .divisor ({1'b0, line_count_reg}),
        .rem     (line_rem)
    );

    // hash in the first half of the remainder pass, step in the second
    assign red_src = cnt_reg[STEP_CNT_W-1] ? step_reg : h_reg;
    assign red_x   = red_src[HASH_W-1:3];
    assign red_rem = LBW'(red_x - red_qd_reg);
    assign red_mod = {red_rem, red_src[2:0]};

    // line index wraps into the store when it is smaller than the line range
    generate
        if (WRAP_NEEDED)
        begin : g_wrap
            localparam int WRSH = LINE_SEL_W + LW;
            localparam int WMW  = LINE_SEL_W + 2;
            localparam longint WRECIP = ((64'd1 << WRSH) + MAX_LINES - 1) / MAX_LINES;
            localparam logic [WMW-1:0] WRECIP_V = WMW'(WRECIP);

            logic [LINE_SEL_W+WMW-1:0] wprod_reg;
            logic [LINE_SEL_W-1:0]     wqd_reg;
            logic [LINE_SEL_W-1:0]     wrap_rem;

            // quotient by reciprocal multiply, then back-multiply
            always_ff @(posedge clk)
            begin
                if (wrap_en)
                begin
                    wprod_reg <= line_rem * WRECIP_V;
                    wqd_reg   <= LINE_SEL_W'(LINE_SEL_W'(wprod_reg >> WRSH)
                                 * LINE_SEL_W'(MAX_LINES));
                end
            end

            assign wrap_rem = line_rem - wqd_reg;
            assign line_idx = LW'(wrap_rem);
        end
        else
        begin : g_nowrap
            assign line_idx = LW'(line_rem);
        end
    endgenerate

    // word address of the probed bit
    assign addr_w = AW'(AW'(line_idx) * AW'(WPL) + AW'(pos_reg >> 6));

    // bit test on the read word
    assign bit_mask = WORD_W'(1) << pos_reg[5:0];
    assign bit_set  = |(ram_rdata & bit_mask);

    // advance hash, carry out of 32 bits shifts the position by 2^32 mod line bits
    assign {h_carry, h_sum} = {1'b0, h_reg} + {1'b0, step_reg};

    always_comb
    begin
        pos_t = $signed({2'b00, pos_reg}) + $signed({2'b00, step_rem_reg})
              - (h_carry ? WRAP_ADJ_S : '0);
        if (pos_t < 0)
        begin
            pos_t = pos_t + LINE_BITS_S;
        end
        else if (pos_t >= LINE_BITS_S)
        begin
            pos_t = pos_t - LINE_BITS_S;
        end
        pos_next = pos_t[PW-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == AW'(STORE_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (line_count_reg == '0) ? ST_DONE : ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == STEP_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = WRAP_NEEDED ? ST_WRAP : ST_SETUP;
                end
            end
            ST_WRAP:
            begin
                if (cnt_reg[1:0] == 2'(WRAP_STEPS - 1))
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                state_next = (probe_count_reg == '0) ? ST_DONE : ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_TEST;
            end
            ST_TEST:
            begin
                if (((act_reg == ACT_QUERY) && !bit_set) || (pcnt_reg == PROBE_W'(1)))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the controller
    always_comb
    begin
        busy      = 1'b1;
        done      = 1'b0;
        div_en    = 1'b0;
        wrap_en   = 1'b0;
        ram_re    = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = ram_rdata | bit_mask;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
            end
            ST_IDLE:
            begin
                busy = 1'b0;
            end
            ST_DIV:
            begin
                div_en = 1'b1;
            end
            ST_WRAP:
            begin
                wrap_en = 1'b1;
            end
            ST_READ:
            begin
                ram_re = 1'b1;
            end
            ST_TEST:
            begin
                ram_we = (act_reg == ACT_INSERT);
            end
            ST_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            line_count_reg  <= '0;
            probe_count_reg <= PROBE_W'(1);
            key_limit_reg   <= '0;
            keys_reg        <= '0;
            cnt_reg         <= '0;
            pcnt_reg        <= '0;
            clr_addr_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;

            // configuration writes
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_LINE_COUNT:  line_count_reg  <= cfg_data[LINE_SEL_W-1:0];
                    REG_PROBE_COUNT: probe_count_reg <= cfg_data[PROBE_W-1:0];
                    REG_KEY_LIMIT:   key_limit_reg   <= cfg_data[COUNT_W-1:0];
                    default:         ;
                endcase
            end

            // clearing pass address
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end

            // saturating insert count, updated when the request is taken
            if (accept && (req.action == ACT_INSERT) && (line_count_reg != '0)
                && (keys_reg != COUNT_MAX))
            begin
                keys_reg <= keys_reg + COUNT_W'(1);
            end

            // remainder step counter
            if (accept)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == ST_DIV)
            begin
                if (cnt_reg == STEP_CNT_W'(DIV_STEPS - 1))
                begin
                    cnt_reg <= '0;
                end
                else
                begin
                    cnt_reg <= cnt_reg + STEP_CNT_W'(1);
                end
            end
            else if (state_reg == ST_WRAP)
            begin
                cnt_reg <= cnt_reg + STEP_CNT_W'(1);
            end

            // probes left
            if (state_reg == ST_SETUP)
            begin
                pcnt_reg <= probe_count_reg;
            end
            else if (state_reg == ST_TEST)
            begin
                pcnt_reg <= pcnt_reg - PROBE_W'(1);
            end
        end
    end

    // item payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            h_reg     <= req.key_hash;
            step_reg  <= probe_step(req.key_hash);
            act_reg   <= req.action;
            match_reg <= (req.action == ACT_QUERY) && (line_count_reg != '0);
        end
        // reciprocal multiply and back-multiply, result taken once settled
        if (state_reg == ST_DIV)
        begin
            red_prod_reg <= red_x * RECIP_V;
            red_qd_reg   <= HX'(HX'(red_prod_reg >> RSH) * HX'(LINE_BYTES));
            if (cnt_reg == STEP_CNT_W'(DIV_STEPS / 2 - 1))
            begin
                pos_base_reg <= red_mod;
            end
            if (cnt_reg == STEP_CNT_W'(DIV_STEPS - 1))
            begin
                step_rem_reg <= red_mod;
            end
        end
        if (state_reg == ST_SETUP)
        begin
            pos_reg <= pos_base_reg;
        end
        if (state_reg == ST_READ)
        begin
            addr_reg <= addr_w;
        end
        if (state_reg == ST_TEST)
        begin
            pos_reg <= pos_next;
            h_reg   <= h_sum;
            if ((act_reg == ACT_QUERY) && !bit_set)
            begin
                match_reg <= 1'b0;
            end
        end
    end

    // bit store
    clbf_ram #(.DEPTH(STORE_WORDS), .AW(AW)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (addr_w),
        .rdata (ram_rdata)
    );

    // result
    assign rsp.may_match = match_reg;
    assign rsp.is_full   = (keys_reg >= key_limit_reg);

endmodule

// ----- sv/clbf_ram.sv -----
// ----------------------------------------------------------------------------
// clbf_ram
// Bit store of the filter: one write port and one read port, 64-bit words,
// read data registered.
// ----------------------------------------------------------------------------
module clbf_ram #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [clbf_pkg::WORD_W-1:0] wdata,
    input  logic                        re,
    input  logic [AW-1:0]               raddr,
    output logic [clbf_pkg::WORD_W-1:0] rdata
);
    import clbf_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/clbf_rem_lane.sv -----
// ----------------------------------------------------------------------------
// clbf_rem_lane
// Serial remainder lane: while en is high, shifts in two dividend bits per cycle,
// msb first, and keeps the running remainder below the divisor by compare and subtract.
// ----------------------------------------------------------------------------
module clbf_rem_lane #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         clr,
    input  logic         en,
    input  logic [1:0]   din,
    input  logic [W:0]   divisor,
    output logic [W-1:0] rem
);
    import clbf_pkg::*;

    logic [W-1:0] rem_reg;
    logic [W-1:0] rem_next;
    logic [W-1:0] rem_mid;

    // one restoring step
    function automatic logic [W-1:0] rem_step(
        input logic [W-1:0] r,
        input logic         b,
        input logic [W:0]   d
    );
        logic [W:0] t;
        t = {r, b};
        if (t >= d)
        begin
            t = t - d;
        end
        return t[W-1:0];
    endfunction

    // two steps per cycle, upper bit first
    always_comb
    begin
        rem_mid  = rem_step(rem_reg, din[1], divisor);
        rem_next = rem_step(rem_mid, din[0], divisor);
    end

    always_ff @(posedge clk)
    begin
        if (clr)
        begin
            rem_reg <= '0;
        end
        else if (en)
        begin
            rem_reg <= rem_next;
        end
    end

    assign rem = rem_reg;

endmodule
